[src/ogsl_pkg.sv]
// ----------------------------------------------------------------------------
// ogsl_pkg: shared types and constants of the obstacle guard steer limiter
// Fixed widths, register indexes, guard constants and the command and status
// records that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ogsl_pkg;

    // Field widths.
    localparam int MM_W      = 13;
    localparam int HEAD_W    = 12;
    localparam int STEER_W   = 11;
    localparam int SPEED_W   = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;

    // Guard geometry in millimeters.
    localparam logic [MM_W-1:0] FAR_MM  = 13'd4000;
    localparam logic [MM_W-1:0] CRIT_MM = 13'd200;

    // Closeness is a Q10 quotient, one bit per divider iteration.
    localparam int DIV_STEPS = 10;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENTER_CENTER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_CENTER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_SIDE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_DELTA     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEER      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEER      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_STEP     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_STEP     = 3'd7;

    // Commands from the controller to the datapath, at most one per cycle.
    typedef struct packed {
        logic load;
        logic prep;
        logic div_step;
        logic mul;
        logic limit;
        logic commit;
    } t_dp_cmd;

    // Status from the datapath, valid from the first divider cycle on.
    typedef struct packed {
        logic div_bypass;
    } t_dp_stat;

endpackage

[src/ogsl_if.sv]
// ----------------------------------------------------------------------------
// ogsl channel interfaces
// Input word, result word and configuration write channels, each with a
// valid/ready handshake and a source and a sink modport.
// ----------------------------------------------------------------------------
interface ogsl_in_if;
    logic               valid;
    logic               ready;
    logic [12:0]        left_mm;
    logic [12:0]        ctr_dist;
    logic [12:0]        rgt_dist;
    logic               left_ok;
    logic               center_ok;
    logic               right_ok;
    logic signed [11:0] target_heading;
    logic signed [10:0] proposed_steer;
    logic [10:0]        proposed_speed;
    logic               model_ok;

    modport source (
        output valid, left_mm, ctr_dist, rgt_dist, left_ok, center_ok, right_ok,
               target_heading, proposed_steer, proposed_speed, model_ok,
        input  ready
    );
    modport sink (
        input  valid, left_mm, ctr_dist, rgt_dist, left_ok, center_ok, right_ok,
               target_heading, proposed_steer, proposed_speed, model_ok,
        output ready
    );
endinterface

interface ogsl_out_if;
    logic               valid;
    logic               ready;
    logic signed [10:0] steer_out;
    logic [10:0]        speed_out;
    logic               blocked;
    logic               fallback;

    modport source (
        output valid, steer_out, speed_out, blocked, fallback,
        input  ready
    );
    modport sink (
        input  valid, steer_out, speed_out, blocked, fallback,
        output ready
    );
endinterface

interface ogsl_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [12:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

[src/ogsl_ctrl.sv]
// ----------------------------------------------------------------------------
// ogsl_ctrl: sequencer of the obstacle guard steer limiter
// Steps one word through prepare, divide, multiply, limit and commit, and
// owns the valid bit of the result register.
// ----------------------------------------------------------------------------
module ogsl_ctrl
    import ogsl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREP   = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_LIMIT  = 3'd4;
    localparam logic [2:0] ST_COMMIT = 3'd5;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt      = '0;
                n_state    = ST_DIV;
            end
            ST_DIV: begin
                if (i_stat.div_bypass) begin
                    n_state = ST_MUL;
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_cnt          = r_cnt + 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_LIMIT;
            end
            ST_LIMIT: begin
                o_cmd.limit = 1'b1;
                n_state     = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_PREP))
        else $error("accepted word did not start preparation");
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("commit would overwrite a pending result");
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_out_valid)
        else $error("committed result not presented");
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt <= CNT_LAST))
        else $error("divider count out of range");
`endif

endmodule

[src/ogsl_dp.sv]
// ----------------------------------------------------------------------------
// ogsl_dp: datapath of the obstacle guard steer limiter
// Configuration registers, avoid side latch, closeness divider, floor and
// cap products, deadband, slew limiters and the result register.
// ----------------------------------------------------------------------------
module ogsl_dp
    import ogsl_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_dp_cmd                     i_cmd,
    output t_dp_stat                    o_stat,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DAT_W-1:0]        i_cfg_data,
    input  logic [MM_W-1:0]             i_left_mm,
    input  logic [MM_W-1:0]             i_ctr_dist,
    input  logic [MM_W-1:0]             i_rgt_dist,
    input  logic                        i_left_ok,
    input  logic                        i_center_ok,
    input  logic                        i_right_ok,
    input  logic signed [HEAD_W-1:0]    i_heading,
    input  logic signed [STEER_W-1:0]   i_steer,
    input  logic [SPEED_W-1:0]          i_speed,
    input  logic                        i_model_ok,
    output logic signed [STEER_W-1:0]   o_steer,
    output logic [SPEED_W-1:0]          o_speed,
    output logic                        o_blocked,
    output logic                        o_fallback
);

    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_RIGHT = 2'd1;
    localparam logic [1:0] SIDE_LEFT  = 2'd2;

    // Configuration.
    logic [MM_W-1:0] r_enter, r_rel_c, r_rel_s, r_delta;
    logic [9:0]      r_min_st, r_max_st, r_st_lim;
    logic [10:0]     r_sp_lim;

    // State carried between words.
    logic [1:0]                 r_side;
    logic signed [STEER_W-1:0]  r_held_steer;
    logic [SPEED_W-1:0]         r_held_speed;

    // Captured word.
    logic [MM_W-1:0]            r_left, r_center, r_right, r_minmm;
    logic signed [HEAD_W-1:0]   r_heading;
    logic signed [STEER_W-1:0]  r_steer;
    logic [SPEED_W-1:0]         r_speed;
    logic                       r_fb;

    // Guard and divider.
    logic            r_guard, r_close_full;
    logic [MM_W-1:0] r_den, r_rem;
    logic [9:0]      r_quo;

    // Products and limited targets.
    logic signed [22:0]         r_pspan;
    logic [18:0]                r_pcap;
    logic signed [STEER_W-1:0]  r_lim_steer;
    logic [SPEED_W-1:0]         r_lim_speed;

    // Result register.
    logic signed [STEER_W-1:0]  r_o_steer;
    logic [SPEED_W-1:0]         r_o_speed;
    logic                       r_o_blocked, r_o_fb;

    assign o_steer    = r_o_steer;
    assign o_speed    = r_o_speed;
    assign o_blocked  = r_o_blocked;
    assign o_fallback = r_o_fb;
    assign o_stat.div_bypass = r_fb || !r_guard || r_close_full;

    // ---------------- load: decode the word ----------------
    logic [MM_W-1:0]           ld_left, ld_center, ld_right, ld_min;
    logic signed [STEER_W-1:0] ld_steer;
    logic [SPEED_W-1:0]        ld_speed;

    always_comb begin
        ld_left   = i_left_ok   ? i_left_mm  : FAR_MM;
        ld_center = i_center_ok ? i_ctr_dist : FAR_MM;
        ld_right  = i_right_ok  ? i_rgt_dist : FAR_MM;
        ld_min    = FAR_MM;
        if (i_left_ok && (i_left_mm < ld_min)) begin
            ld_min = i_left_mm;
        end
        if (i_center_ok && (i_ctr_dist < ld_min)) begin
            ld_min = i_ctr_dist;
        end
        if (i_right_ok && (i_rgt_dist < ld_min)) begin
            ld_min = i_rgt_dist;
        end
        priority if (i_steer > 11'sd900) begin
            ld_steer = 11'sd900;
        end else if (i_steer < -11'sd900) begin
            ld_steer = -11'sd900;
        end else begin
            ld_steer = i_steer;
        end
        ld_speed = (i_speed > 11'd1024) ? 11'd1024 : i_speed;
    end

    // ---------------- prep: release, side choice, divider setup ----------------
    logic              pr_release, pr_guard, pr_full;
    logic [1:0]        pr_side;
    logic signed [13:0] pr_rl, pr_lr, pr_delta, pr_den;
    logic signed [11:0] pr_held;
    logic signed [12:0] pr_head;
    logic [11:0]       pr_held_abs;
    logic [12:0]       pr_head_abs;
    logic [MM_W-1:0]   pr_num;

    always_comb begin
        pr_release = (r_side != SIDE_NONE) && (r_center >= r_rel_c) &&
                     (r_left >= r_rel_s) && (r_right >= r_rel_s);
        pr_side    = pr_release ? SIDE_NONE : r_side;
        pr_guard   = r_center < r_enter;
        pr_rl      = $signed({1'b0, r_right}) - $signed({1'b0, r_left});
        pr_lr      = -pr_rl;
        pr_delta   = $signed({1'b0, r_delta});
        pr_held    = {r_held_steer[STEER_W-1], r_held_steer};
        pr_held_abs = pr_held[11] ? 12'(-pr_held) : 12'(pr_held);
        pr_head    = {r_heading[HEAD_W-1], r_heading};
        pr_head_abs = pr_head[12] ? 13'(-pr_head) : 13'(pr_head);
        if (pr_guard && (pr_side == SIDE_NONE)) begin
            priority if (pr_rl > pr_delta) begin
                pr_side = SIDE_RIGHT;
            end else if (pr_lr > pr_delta) begin
                pr_side = SIDE_LEFT;
            end else if (pr_held_abs >= 12'd50) begin
                pr_side = pr_held[11] ? SIDE_LEFT : SIDE_RIGHT;
            end else if (pr_head_abs >= 13'd50) begin
                pr_side = pr_head[12] ? SIDE_LEFT : SIDE_RIGHT;
            end else begin
                pr_side = SIDE_RIGHT;
            end
        end
        pr_den  = $signed({1'b0, r_enter}) - $signed({1'b0, CRIT_MM});
        pr_num  = r_enter - r_center;
        pr_full = (pr_den <= 14'sd0) || ($signed({1'b0, pr_num}) >= pr_den);
    end

    // ---------------- divider step: one quotient bit ----------------
    logic [MM_W:0] dv_rem2, dv_diff;
    logic          dv_bit;

    always_comb begin
        dv_rem2 = {r_rem, 1'b0};
        dv_bit  = dv_rem2 >= {1'b0, r_den};
        dv_diff = dv_rem2 - {1'b0, r_den};
    end

    // ---------------- multiply ----------------
    logic [10:0]        mu_close;
    logic signed [10:0] mu_span;

    always_comb begin
        mu_close = r_close_full ? 11'd1024 : {1'b0, r_quo};
        mu_span  = $signed({1'b0, r_max_st}) - $signed({1'b0, r_min_st});
    end

    // ---------------- limit: floor, cap, deadband ----------------
    logic               li_neg;
    logic [22:0]        li_mag;
    logic [12:0]        li_q;
    logic signed [13:0] li_floor_raw;
    logic signed [11:0] li_floor;
    logic [19:0]        li_capsum;
    logic [10:0]        li_cap;
    logic signed [11:0] li_steer;
    logic [SPEED_W-1:0] li_speed;
    logic [11:0]        li_steer_abs;
    logic [12:0]        li_head_abs;
    logic signed [12:0] li_head;

    always_comb begin
        li_neg = r_pspan[22];
        li_mag = li_neg ? 23'(-r_pspan) : 23'(r_pspan);
        li_q   = li_mag[22:10];
        li_floor_raw = $signed({4'b0, r_min_st}) +
                       (li_neg ? -$signed({1'b0, li_q}) : $signed({1'b0, li_q}));
        priority if (li_floor_raw < 14'sd0) begin
            li_floor = 12'sd0;
        end else if (li_floor_raw > 14'sd900) begin
            li_floor = 12'sd900;
        end else begin
            li_floor = 12'(li_floor_raw);
        end
        li_capsum = {1'b0, r_pcap} + 20'd512;
        li_cap    = 11'd614 - {1'b0, li_capsum[19:10]};
        li_steer  = {r_steer[STEER_W-1], r_steer};
        li_speed  = r_speed;
        if (r_guard) begin
            if ((r_side == SIDE_RIGHT) && (li_steer < li_floor)) begin
                li_steer = li_floor;
            end else if ((r_side == SIDE_LEFT) && (li_steer > -li_floor)) begin
                li_steer = -li_floor;
            end
            if (li_speed > li_cap) begin
                li_speed = li_cap;
            end
        end
        li_head      = {r_heading[HEAD_W-1], r_heading};
        li_head_abs  = li_head[12] ? 13'(-li_head) : 13'(li_head);
        li_steer_abs = li_steer[11] ? 12'(-li_steer) : 12'(li_steer);
        if ((r_minmm >= 13'd850) && (li_head_abs < 13'd10) && (li_steer_abs < 12'd150)) begin
            li_steer = 12'sd0;
        end
    end

    // ---------------- commit: slew limiters ----------------
    logic signed [12:0] cm_ds, cm_slim, cm_st;
    logic signed [12:0] cm_dp, cm_plim, cm_sp;

    always_comb begin
        cm_ds   = $signed({{2{r_lim_steer[STEER_W-1]}}, r_lim_steer}) -
                  $signed({{2{r_held_steer[STEER_W-1]}}, r_held_steer});
        cm_slim = $signed({3'b0, r_st_lim});
        priority if (cm_ds > cm_slim) begin
            cm_st = $signed({{2{r_held_steer[STEER_W-1]}}, r_held_steer}) + cm_slim;
        end else if (cm_ds < -cm_slim) begin
            cm_st = $signed({{2{r_held_steer[STEER_W-1]}}, r_held_steer}) - cm_slim;
        end else begin
            cm_st = $signed({{2{r_lim_steer[STEER_W-1]}}, r_lim_steer});
        end
        cm_dp   = $signed({2'b0, r_lim_speed}) - $signed({2'b0, r_held_speed});
        cm_plim = $signed({2'b0, r_sp_lim});
        priority if (cm_dp > cm_plim) begin
            cm_sp = $signed({2'b0, r_held_speed}) + cm_plim;
        end else if (cm_dp < -cm_plim) begin
            cm_sp = $signed({2'b0, r_held_speed}) - cm_plim;
        end else begin
            cm_sp = $signed({2'b0, r_lim_speed});
        end
    end

    // ---------------- control state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enter      <= 13'd600;
            r_rel_c      <= 13'd900;
            r_rel_s      <= 13'd400;
            r_delta      <= 13'd100;
            r_min_st     <= 10'd200;
            r_max_st     <= 10'd450;
            r_st_lim     <= 10'd100;
            r_sp_lim     <= 11'd51;
            r_side       <= SIDE_NONE;
            r_held_steer <= '0;
            r_held_speed <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ENTER_CENTER:   r_enter  <= i_cfg_data;
                    CFG_RELEASE_CENTER: r_rel_c  <= i_cfg_data;
                    CFG_RELEASE_SIDE:   r_rel_s  <= i_cfg_data;
                    CFG_SIDE_DELTA:     r_delta  <= i_cfg_data;
                    CFG_MIN_STEER:      r_min_st <= i_cfg_data[9:0];
                    CFG_MAX_STEER:      r_max_st <= i_cfg_data[9:0];
                    CFG_STEER_STEP:     r_st_lim <= i_cfg_data[9:0];
                    CFG_SPEED_STEP:     r_sp_lim <= i_cfg_data[10:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.prep && !r_fb) begin
                r_side <= pr_side;
            end
            if (i_cmd.commit && !r_fb) begin
                r_held_steer <= STEER_W'(cm_st);
                r_held_speed <= SPEED_W'(cm_sp);
            end
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_left    <= ld_left;
            r_center  <= ld_center;
            r_right   <= ld_right;
            r_minmm   <= ld_min;
            r_heading <= i_heading;
            r_steer   <= ld_steer;
            r_speed   <= ld_speed;
            r_fb      <= !i_model_ok || !(i_left_ok || i_center_ok || i_right_ok);
        end
        if (i_cmd.prep) begin
            r_guard      <= pr_guard;
            r_close_full <= pr_full;
            r_den        <= pr_den[MM_W-1:0];
            r_rem        <= pr_num;
            r_quo        <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= dv_bit ? dv_diff[MM_W-1:0] : dv_rem2[MM_W-1:0];
            r_quo <= {r_quo[8:0], dv_bit};
        end
        if (i_cmd.mul) begin
            r_pspan <= 23'($signed({1'b0, mu_close})) * 23'(mu_span);
            r_pcap  <= 19'(mu_close) * 19'd307;
        end
        if (i_cmd.limit) begin
            r_lim_steer <= STEER_W'(li_steer);
            r_lim_speed <= li_speed;
        end
        if (i_cmd.commit) begin
            if (r_fb) begin
                r_o_steer   <= r_held_steer;
                r_o_speed   <= '0;
                r_o_blocked <= 1'b1;
                r_o_fb      <= 1'b1;
            end else begin
                r_o_steer   <= STEER_W'(cm_st);
                r_o_speed   <= SPEED_W'(cm_sp);
                r_o_blocked <= cm_sp <= 13'sd10;
                r_o_fb      <= 1'b0;
            end
        end
    end

endmodule

[src/obstacle_guard_steer_limiter.sv]
// ----------------------------------------------------------------------------
// obstacle_guard_steer_limiter: top level
// Guards a planner's steer and speed against a near front obstacle and slew
// limits both against the values held from the previous control step.
// ----------------------------------------------------------------------------
// Each accepted word yields exactly one result word and is stepped through
// load, prepare, divide, multiply, limit and commit. The divider works only
// when the guard is active and the obstacle lies between the critical
// distance and the enter distance: the closeness quotient then comes from a
// restoring divider that produces one of its 10 bits per cycle. The result
// register decouples the two sides, so the next word is accepted while a
// result still waits; only the final commit cycle stalls when the previous
// result has not yet been taken. Configuration writes are accepted in every
// cycle and must only be issued while no word is in flight.
// ----------------------------------------------------------------------------
module obstacle_guard_steer_limiter
    import ogsl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    ogsl_in_if.sink    i_in,
    ogsl_out_if.source o_out,
    ogsl_cfg_if.sink   i_cfg
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Configuration registers live in the datapath and take a write at once.
    assign i_cfg.ready = 1'b1;

    // The controller sequences one word at a time through the datapath.
    ogsl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // The datapath holds the avoid side latch, the held steer and speed, the
    // closeness divider and the result register.
    ogsl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_idx   (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_left_mm   (i_in.left_mm),
        .i_ctr_dist  (i_in.ctr_dist),
        .i_rgt_dist  (i_in.rgt_dist),
        .i_left_ok   (i_in.left_ok),
        .i_center_ok (i_in.center_ok),
        .i_right_ok  (i_in.right_ok),
        .i_heading   (i_in.target_heading),
        .i_steer     (i_in.proposed_steer),
        .i_speed     (i_in.proposed_speed),
        .i_model_ok  (i_in.model_ok),
        .o_steer     (o_out.steer_out),
        .o_speed     (o_out.speed_out),
        .o_blocked   (o_out.blocked),
        .o_fallback  (o_out.fallback)
    );

endmodule

[tb/tb_obstacle_guard_steer_limiter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_obstacle_guard_steer_limiter: self-checking bench for the steer limiter
// Drives range words through the input channel and predicts every steer
// command in a small scoreboard. The bench runs a directed opening, then
// random phases under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_obstacle_guard_steer_limiter;
    import ogsl_pkg::*;

    // Run shape.
    localparam int NUM_REGS    = 8;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_WORDS = 88;
    localparam int DRAIN_TAIL  = 24;
    localparam int STALL_LIMIT = 4000;

    // Fixed-point limits and thresholds of the control step.
    localparam int STEER_LIMIT    = 900;
    localparam int Q10_ONE        = 1024;
    localparam int Q10_HALF       = 512;
    localparam int CAP_BASE       = 614;
    localparam int CAP_SLOPE      = 307;
    localparam int SIGN_THRESH    = 50;
    localparam int OPEN_MM        = 850;
    localparam int STRAIGHT_HEAD  = 10;
    localparam int DEADBAND_STEER = 150;
    localparam int BLOCKED_SPEED  = 10;

    // Latched avoid direction: the sign that the steer floor is pushed toward.
    localparam int AVOID_NONE  = 0;
    localparam int AVOID_RIGHT = 1;
    localparam int AVOID_LEFT  = -1;

    // Register settings that the random phases run under.
    typedef enum int {PROF_RESET, PROF_WIDE, PROF_INERT, PROF_TIGHT, PROF_RANDOM} t_profile;

    // One input word as the planner and the range sensors deliver it.
    typedef struct {
        logic [12:0]        left_mm, ctr_dist, rgt_dist;
        logic               left_ok, center_ok, right_ok;
        logic signed [11:0] target_heading;
        logic signed [10:0] proposed_steer;
        logic [10:0]        proposed_speed;
        logic               model_ok;
    } t_sensor_word;

    // One result word: the limited steering command.
    typedef struct {
        logic signed [10:0] steer_out;
        logic [10:0]        speed_out;
        logic               blocked;
        logic               fallback;
    } t_steer_cmd;

    // ------------------------------------------------------------------------
    // Scoreboard. It keeps its own copy of the guard registers and of the
    // latched side and held steer and speed, predicts one command per
    // accepted word and checks commands against the oldest prediction.
    // ------------------------------------------------------------------------
    class steer_guard_scoreboard;
        int enter_mm, release_center_mm, release_side_mm, side_delta_mm;
        int min_steer, max_steer, steer_step, speed_step;
        int avoid_dir, held_steer, held_speed;
        t_steer_cmd expected_cmds[$];
        int errors, n_words, n_checked, n_fallback, n_guarded;

        function new();
            enter_mm          = 600;
            release_center_mm = 900;
            release_side_mm   = 400;
            side_delta_mm     = 100;
            min_steer         = 200;
            max_steer         = 450;
            steer_step        = 100;
            speed_step        = 51;
            avoid_dir         = AVOID_NONE;
            held_steer        = 0;
            held_speed        = 0;
        endfunction

        static function int clamp_int(int v, int lo, int hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        static function int abs_int(int v);
            return v < 0 ? -v : v;
        endfunction

        static function int slew_int(int target, int cur, int lim);
            if (target - cur > lim) return cur + lim;
            if (target - cur < -lim) return cur - lim;
            return target;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                CFG_ENTER_CENTER:   enter_mm          = data;
                CFG_RELEASE_CENTER: release_center_mm = data;
                CFG_RELEASE_SIDE:   release_side_mm   = data;
                CFG_SIDE_DELTA:     side_delta_mm     = data;
                CFG_MIN_STEER:      min_steer         = data[9:0];
                CFG_MAX_STEER:      max_steer         = data[9:0];
                CFG_STEER_STEP:     steer_step        = data[9:0];
                CFG_SPEED_STEP:     speed_step        = data[10:0];
                default: ;
            endcase
        endfunction

        function t_steer_cmd predict_steer_cmd(t_sensor_word w);
            int         mm[3];
            bit         ok[3];
            int         guard_mm[3];
            int         heading, steer, speed, open_min;
            int         den, close_q10, span, floor_steer, speed_cap;
            t_steer_cmd cmd;
            mm[0] = w.left_mm;
            mm[1] = w.ctr_dist;
            mm[2] = w.rgt_dist;
            ok[0] = w.left_ok;
            ok[1] = w.center_ok;
            ok[2] = w.right_ok;
            heading = w.target_heading;
            steer   = clamp_int(w.proposed_steer, -STEER_LIMIT, STEER_LIMIT);
            speed   = clamp_int(w.proposed_speed, 0, Q10_ONE);

            // Fallback repeats the held steer at zero speed and leaves the
            // state alone.
            if (!w.model_ok || !(ok[0] || ok[1] || ok[2])) begin
                n_fallback++;
                cmd.steer_out = 11'(held_steer);
                cmd.speed_out = '0;
                cmd.blocked   = 1'b1;
                cmd.fallback  = 1'b1;
                return cmd;
            end

            // Invalid sides read as far for the guard and drop out of the
            // open space minimum.
            open_min = int'(FAR_MM);
            for (int i = 0; i < 3; i++) begin
                guard_mm[i] = ok[i] ? mm[i] : int'(FAR_MM);
                if (ok[i] && mm[i] < open_min)
                    open_min = mm[i];
            end

            if (avoid_dir != AVOID_NONE && guard_mm[1] >= release_center_mm &&
                guard_mm[0] >= release_side_mm && guard_mm[2] >= release_side_mm)
                avoid_dir = AVOID_NONE;

            if (guard_mm[1] < enter_mm) begin
                n_guarded++;
                if (avoid_dir == AVOID_NONE) begin
                    if (guard_mm[2] - guard_mm[0] > side_delta_mm)
                        avoid_dir = AVOID_RIGHT;
                    else if (guard_mm[0] - guard_mm[2] > side_delta_mm)
                        avoid_dir = AVOID_LEFT;
                    else if (abs_int(held_steer) >= SIGN_THRESH)
                        avoid_dir = held_steer > 0 ? AVOID_RIGHT : AVOID_LEFT;
                    else if (abs_int(heading) >= SIGN_THRESH)
                        avoid_dir = heading > 0 ? AVOID_RIGHT : AVOID_LEFT;
                    else
                        avoid_dir = AVOID_RIGHT;
                end
                den = enter_mm - int'(CRIT_MM);
                if (den <= 0)
                    close_q10 = Q10_ONE;
                else
                    close_q10 = clamp_int(((enter_mm - guard_mm[1]) * Q10_ONE) / den,
                                          0, Q10_ONE);
                span        = max_steer - min_steer;
                floor_steer = clamp_int(min_steer + (close_q10 * span) / Q10_ONE,
                                        0, STEER_LIMIT);
                if (avoid_dir * steer < floor_steer)
                    steer = avoid_dir * floor_steer;
                speed_cap = CAP_BASE - ((close_q10 * CAP_SLOPE + Q10_HALF) >> 10);
                if (speed > speed_cap)
                    speed = speed_cap;
            end

            if (open_min >= OPEN_MM && abs_int(heading) < STRAIGHT_HEAD &&
                abs_int(steer) < DEADBAND_STEER)
                steer = 0;

            held_steer    = slew_int(steer, held_steer, steer_step);
            held_speed    = slew_int(speed, held_speed, speed_step);
            cmd.steer_out = 11'(held_steer);
            cmd.speed_out = 11'(held_speed);
            cmd.blocked   = held_speed <= BLOCKED_SPEED;
            cmd.fallback  = 1'b0;
            return cmd;
        endfunction

        function void note_word(t_sensor_word w);
            expected_cmds.push_back(predict_steer_cmd(w));
            n_words++;
        endfunction

        function void check_result(t_steer_cmd got);
            t_steer_cmd want;
            if (expected_cmds.size() == 0) begin
                $error("result word with nothing expected: steer_out %0d speed_out %0d",
                       got.steer_out, got.speed_out);
                errors++;
                return;
            end
            want = expected_cmds.pop_front();
            n_checked++;
            if (got.steer_out !== want.steer_out) begin
                $error("steer_out: expected %0d, actual %0d", want.steer_out, got.steer_out);
                errors++;
            end
            if (got.speed_out !== want.speed_out) begin
                $error("speed_out: expected %0d, actual %0d", want.speed_out, got.speed_out);
                errors++;
            end
            if (got.blocked !== want.blocked) begin
                $error("blocked: expected %0b, actual %0b", want.blocked, got.blocked);
                errors++;
            end
            if (got.fallback !== want.fallback) begin
                $error("fallback: expected %0b, actual %0b", want.fallback, got.fallback);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ogsl_in_if  in_ch();
    ogsl_out_if out_ch();
    ogsl_cfg_if cfg_ch();

    obstacle_guard_steer_limiter u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    steer_guard_scoreboard sb;

    // Idle rates in percent for the word sender and the command receiver.
    int src_idle_pct;
    int snk_idle_pct;

    // The random walk of the center distance that models an approach and a
    // retreat from a front obstacle.
    int center_walk;
    int stall_cycles;
    int n_settings;
    int profile_vals[NUM_REGS];

    t_profile phase_plan[NUM_PHASES] =
        '{PROF_RANDOM, PROF_WIDE, PROF_TIGHT, PROF_RANDOM, PROF_INERT, PROF_RESET};

    t_sensor_word directed_words[$];

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver decides at every falling edge whether it takes a word at
    // the next rising edge.
    always @(negedge clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // All handshakes are observed at the rising edge. Input words feed the
    // predictor, result words are checked, and register writes update the
    // predictor's copy of the registers. The watchdog counts cycles in which
    // no channel moves a word.
    always @(posedge clk) begin
        t_sensor_word seen_word;
        t_steer_cmd   seen_cmd;
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(cfg_ch.index, cfg_ch.data);
            if (in_ch.valid && in_ch.ready) begin
                seen_word.left_mm        = in_ch.left_mm;
                seen_word.ctr_dist       = in_ch.ctr_dist;
                seen_word.rgt_dist       = in_ch.rgt_dist;
                seen_word.left_ok        = in_ch.left_ok;
                seen_word.center_ok      = in_ch.center_ok;
                seen_word.right_ok       = in_ch.right_ok;
                seen_word.target_heading = in_ch.target_heading;
                seen_word.proposed_steer = in_ch.proposed_steer;
                seen_word.proposed_speed = in_ch.proposed_speed;
                seen_word.model_ok       = in_ch.model_ok;
                sb.note_word(seen_word);
            end
            if (out_ch.valid && out_ch.ready) begin
                seen_cmd.steer_out = out_ch.steer_out;
                seen_cmd.speed_out = out_ch.speed_out;
                seen_cmd.blocked   = out_ch.blocked;
                seen_cmd.fallback  = out_ch.fallback;
                sb.check_result(seen_cmd);
            end
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles.", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Builds a word from plain numbers; the valid bits come as
    // {left, center, right}.
    function automatic t_sensor_word make_word(int left, int center, int right,
                                               logic [2:0] ok_bits, int heading,
                                               int steer, int speed, logic model_ok);
        t_sensor_word w;
        w.left_mm        = 13'(left);
        w.ctr_dist       = 13'(center);
        w.rgt_dist       = 13'(right);
        w.left_ok        = ok_bits[2];
        w.center_ok      = ok_bits[1];
        w.right_ok       = ok_bits[0];
        w.target_heading = 12'(heading);
        w.proposed_steer = 11'(steer);
        w.proposed_speed = 11'(speed);
        w.model_ok       = model_ok;
        return w;
    endfunction

    // A distance spread around a base value, kept inside the 13-bit field.
    function automatic logic [12:0] near_mm(int base, int spread);
        int v;
        v = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 8191)
            v = 8191;
        return 13'(v);
    endfunction

    // Most random words follow an obstacle that drifts nearer and farther
    // with sides near the center distance; the rest are unrelated noise.
    // Proposals are mostly in range, with raw field values mixed in.
    function automatic t_sensor_word random_word();
        t_sensor_word w;
        int           roll;
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
            if ($urandom_range(0, 29) == 0)
                center_walk = $urandom_range(0, 3000);
            center_walk += int'($urandom_range(0, 400)) - 200;
            if (center_walk < 0)
                center_walk = 0;
            if (center_walk > 3000)
                center_walk = 3000;
            w.ctr_dist = 13'(center_walk);
            w.left_mm  = near_mm(center_walk + 300, 600);
            w.rgt_dist = near_mm(center_walk + 300, 600);
        end else begin
            w.left_mm  = 13'($urandom);
            w.ctr_dist = 13'($urandom);
            w.rgt_dist = 13'($urandom);
        end
        w.left_ok   = $urandom_range(0, 9) != 0;
        w.center_ok = $urandom_range(0, 9) != 0;
        w.right_ok  = $urandom_range(0, 9) != 0;
        w.model_ok  = $urandom_range(0, 19) != 0;

        roll = $urandom_range(0, 99);
        if (roll < 40)
            w.target_heading = 12'(int'($urandom_range(0, 120)) - 60);
        else if (roll < 90)
            w.target_heading = 12'(int'($urandom_range(0, 3600)) - 1800);
        else
            w.target_heading = 12'($urandom);

        roll = $urandom_range(0, 99);
        if (roll < 20)
            w.proposed_steer = 11'(int'($urandom_range(0, 400)) - 200);
        else if (roll < 85)
            w.proposed_steer = 11'(int'($urandom_range(0, 1800)) - 900);
        else
            w.proposed_steer = 11'($urandom);

        if ($urandom_range(0, 99) < 85)
            w.proposed_speed = 11'($urandom_range(0, 1024));
        else
            w.proposed_speed = 11'($urandom);
        return w;
    endfunction

    // Offers one word, idling first at the sender's rate, and returns at the
    // falling edge after the word was taken. Valid stays high when the next
    // word follows without a gap.
    task automatic send_word(input t_sensor_word w);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.left_mm        <= w.left_mm;
        in_ch.ctr_dist       <= w.ctr_dist;
        in_ch.rgt_dist       <= w.rgt_dist;
        in_ch.left_ok        <= w.left_ok;
        in_ch.center_ok      <= w.center_ok;
        in_ch.right_ok       <= w.right_ok;
        in_ch.target_heading <= w.target_heading;
        in_ch.proposed_steer <= w.proposed_steer;
        in_ch.proposed_speed <= w.proposed_speed;
        in_ch.model_ok       <= w.model_ok;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stops sending and waits until every predicted command has come back,
    // then lets the given number of further cycles pass.
    task automatic wait_drained(input int tail);
        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.expected_cmds.size() != 0);
        repeat (tail) @(negedge clk);
    endtask

    // Writes all guard registers with one setting. Called only while no
    // word is in flight.
    task automatic write_profile(input t_profile prof);
        case (prof)
            PROF_RESET: begin
                profile_vals[CFG_ENTER_CENTER]   = 600;
                profile_vals[CFG_RELEASE_CENTER] = 900;
                profile_vals[CFG_RELEASE_SIDE]   = 400;
                profile_vals[CFG_SIDE_DELTA]     = 100;
                profile_vals[CFG_MIN_STEER]      = 200;
                profile_vals[CFG_MAX_STEER]      = 450;
                profile_vals[CFG_STEER_STEP]     = 100;
                profile_vals[CFG_SPEED_STEP]     = 51;
            end
            // The guard acts almost always, releases on the center only at its
            // largest reading, and the slew limits are wide open.
            PROF_WIDE: begin
                profile_vals[CFG_ENTER_CENTER]   = 8191;
                profile_vals[CFG_RELEASE_CENTER] = 8191;
                profile_vals[CFG_RELEASE_SIDE]   = 0;
                profile_vals[CFG_SIDE_DELTA]     = 0;
                profile_vals[CFG_MIN_STEER]      = 0;
                profile_vals[CFG_MAX_STEER]      = 900;
                profile_vals[CFG_STEER_STEP]     = 900;
                profile_vals[CFG_SPEED_STEP]     = 1024;
            end
            // The guard never acts and the steer is frozen.
            PROF_INERT: begin
                profile_vals[CFG_ENTER_CENTER]   = 0;
                profile_vals[CFG_RELEASE_CENTER] = 0;
                profile_vals[CFG_RELEASE_SIDE]   = 8191;
                profile_vals[CFG_SIDE_DELTA]     = 8191;
                profile_vals[CFG_MIN_STEER]      = 900;
                profile_vals[CFG_MAX_STEER]      = 0;
                profile_vals[CFG_STEER_STEP]     = 0;
                profile_vals[CFG_SPEED_STEP]     = 1024;
            end
            // Enter distance inside the critical distance, so the divider
            // is bypassed and closeness is full; the speed is frozen.
            PROF_TIGHT: begin
                profile_vals[CFG_ENTER_CENTER]   = 150;
                profile_vals[CFG_RELEASE_CENTER] = 300;
                profile_vals[CFG_RELEASE_SIDE]   = 200;
                profile_vals[CFG_SIDE_DELTA]     = 37;
                profile_vals[CFG_MIN_STEER]      = 450;
                profile_vals[CFG_MAX_STEER]      = 200;
                profile_vals[CFG_STEER_STEP]     = 37;
                profile_vals[CFG_SPEED_STEP]     = 0;
            end
            default: begin
                profile_vals[CFG_ENTER_CENTER]   = $urandom_range(0, 2000);
                profile_vals[CFG_RELEASE_CENTER] = $urandom_range(0, 3000);
                profile_vals[CFG_RELEASE_SIDE]   = $urandom_range(0, 1500);
                profile_vals[CFG_SIDE_DELTA]     = $urandom_range(0, 600);
                profile_vals[CFG_MIN_STEER]      = $urandom_range(0, 900);
                profile_vals[CFG_MAX_STEER]      = $urandom_range(0, 900);
                profile_vals[CFG_STEER_STEP]     = $urandom_range(1, 300);
                profile_vals[CFG_SPEED_STEP]     = $urandom_range(1, 300);
            end
        endcase
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= CFG_IDX_W'(i);
            cfg_ch.data  <= CFG_DAT_W'(profile_vals[i]);
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            @(negedge clk);
        end
        cfg_ch.valid <= 1'b0;
        n_settings++;
    endtask

    initial begin
        // Every input starts at a known value before reset is released.
        rst_n                = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.left_mm        = '0;
        in_ch.ctr_dist       = '0;
        in_ch.rgt_dist       = '0;
        in_ch.left_ok        = 1'b0;
        in_ch.center_ok      = 1'b0;
        in_ch.right_ok       = 1'b0;
        in_ch.target_heading = '0;
        in_ch.proposed_steer = '0;
        in_ch.proposed_speed = '0;
        in_ch.model_ok       = 1'b0;
        out_ch.ready         = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        stall_cycles         = 0;
        center_walk          = 2500;
        n_settings           = 1;
        src_idle_pct         = 33;
        snk_idle_pct         = 56;
        sb                   = new();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening under the reset settings. Each choice of avoid
        // side is set up from an unlatched state, with a small held steer
        // except where the held steer picks the side, and a far center with
        // clear sides in between releases the latch. Open space with a
        // straight heading and a small proposal exercises the deadband.
        directed_words.push_back(make_word(3000, 3000, 3000, 3'b111, 0, 0, 1024, 1'b1));
        directed_words.push_back(make_word(3000, 3000, 3000, 3'b111, 5, 140, 1024, 1'b1));
        directed_words.push_back(make_word(8191, 8191, 8191, 3'b111, 1800, 900, 1024, 1'b1));
        // Sides even: the sign of the held steer picks right.
        directed_words.push_back(make_word(3000, 500, 3000, 3'b111, 0, 0, 1024, 1'b1));
        directed_words.push_back(make_word(3000, 1000, 3000, 3'b111, 0, 0, 1024, 1'b1));
        directed_words.push_back(make_word(3000, 1000, 3000, 3'b111, 0, 0, 1024, 1'b1));
        // Sides even, held steer small: the heading picks left.
        directed_words.push_back(make_word(3000, 500, 3000, 3'b111, -300, 0, 1024, 1'b1));
        directed_words.push_back(make_word(3000, 1000, 3000, 3'b111, 0, 0, 1024, 1'b1));
        // Nothing decides, so the side defaults to right.
        directed_words.push_back(make_word(3000, 500, 3000, 3'b111, 0, 0, 1024, 1'b1));
        directed_words.push_back(make_word(3000, 1000, 3000, 3'b111, 0, 0, 1024, 1'b1));
        // The clearer side wins when the difference passes the delta.
        directed_words.push_back(make_word(300, 400, 3000, 3'b111, 0, 0, 1024, 1'b1));
        directed_words.push_back(make_word(3000, 1000, 3000, 3'b111, 0, 0, 1024, 1'b1));
        directed_words.push_back(make_word(3000, 400, 300, 3'b111, 0, 0, 1024, 1'b1));
        // Inside the critical distance the closeness saturates.
        directed_words.push_back(make_word(3000, 100, 3000, 3'b111, 0, -900, 1024, 1'b1));
        // Invalid sides read as far; an invalid center hides a near reading.
        directed_words.push_back(make_word(0, 0, 0, 3'b010, 0, 0, 1024, 1'b1));
        directed_words.push_back(make_word(5000, 10, 5000, 3'b101, 0, 0, 1024, 1'b1));
        // Fallback by the model flag and by no valid range at all.
        directed_words.push_back(make_word(3000, 3000, 3000, 3'b111, 0, 0, 1024, 1'b0));
        directed_words.push_back(make_word(3000, 3000, 3000, 3'b000, 0, 0, 1024, 1'b1));
        // Proposals and headings outside their ranges, and field extremes.
        directed_words.push_back(make_word(3000, 3000, 3000, 3'b111, -2048, -1024, 2047, 1'b1));
        directed_words.push_back(make_word(0, 0, 0, 3'b111, 2047, 1023, 1025, 1'b1));
        directed_words.push_back(make_word(8191, 8191, 8191, 3'b111, -1800, -900, 0, 1'b1));
        foreach (directed_words[i])
            send_word(directed_words[i]);

        // Random phases: two with a slow receiver, two with a slow sender,
        // two without idling, each under its own register setting.
        for (int p = 0; p < NUM_PHASES; p++) begin
            src_idle_pct = (p < 2) ? 33 : ((p < 4) ? 56 : 0);
            snk_idle_pct = (p < 2) ? 56 : ((p < 4) ? 33 : 0);
            wait_drained(DRAIN_TAIL);
            write_profile(phase_plan[p]);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // Once in the run the sender holds off until the result
                // side has fully drained.
                if (p == 0 && n == PHASE_WORDS / 2)
                    wait_drained(0);
                send_word(random_word());
            end
        end

        wait_drained(DRAIN_TAIL);

        $display("Covered %0d words and %0d checked commands under %0d register settings.",
                 sb.n_words, sb.n_checked, n_settings);
        $display("%0d steps took the fallback path and %0d ran with the guard active.",
                 sb.n_fallback, sb.n_guarded);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
